>>> rtl/rpar_pkg.sv
// Package for the random pick block that avoids recently chosen ids.
// Holds the beat types, the sequencer state type, register codes and sizing constants.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rpar_pkg;

    // Defaults for the top level parameters.
    localparam int RECENT_DEPTH_DEF = 4;
    localparam int MAX_SOUNDS_DEF   = 256;

    // Field widths that the interface fixes.
    localparam int RAND_W     = 31;
    localparam int TYPE_W     = 2;
    localparam int SOUND_ID_W = 8;
    localparam int SC_W       = 9;
    localparam int NTH_W      = 8;

    // One lane per random word: the first draw and eight retries.
    localparam int NUM_LANES = 9;

    // Remainder units retire two dividend bits per cycle.
    localparam int DIV_W     = 32;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_SOUND_COUNT = 1'b0;
    localparam logic REG_PLAY_NTH    = 1'b1;

    typedef struct packed {
        logic [RAND_W-1:0] random_0;
        logic [RAND_W-1:0] random_1;
        logic [RAND_W-1:0] random_2;
        logic [RAND_W-1:0] random_3;
        logic [RAND_W-1:0] random_4;
        logic [RAND_W-1:0] random_5;
        logic [RAND_W-1:0] random_6;
        logic [RAND_W-1:0] random_7;
        logic [RAND_W-1:0] random_8;
        logic [TYPE_W-1:0] sound_type_in;
    } in_beat_t;

    typedef struct packed {
        logic [SOUND_ID_W-1:0] sound_id;
        logic [TYPE_W-1:0]     sound_type_out;
    } out_beat_t;

    // Control from the sequencer to the remainder lanes.
    typedef struct packed {
        logic start;
        logic step;
    } lane_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PICK
    } rpar_state_t;

endpackage

`default_nettype wire

>>> rtl/rpar_mod_lane.sv
// One remainder lane: computes a random word modulo the sound count, two bits per cycle.
// Depends on rpar_pkg for the word width, dividend width and lane control struct.
`default_nettype none

module rpar_mod_lane #(
    parameter int DW = 9
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rpar_pkg::lane_ctrl_t     ctrl,
    input  wire logic [rpar_pkg::RAND_W-1:0] word,
    input  wire logic [DW-1:0]            divisor,
    output logic      [DW-1:0]            rem
);
    import rpar_pkg::*;

    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] div_next;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    rem_next;
    logic [DW:0]      dvs_ext;
    logic [DW:0]      t1;
    logic [DW:0]      r1;
    logic [DW:0]      t2;
    logic [DW:0]      r2;

    // Restoring division step: the partial remainder stays below the divisor,
    // so after shifting in one bit it needs at most one subtraction.
    always_comb
    begin
        dvs_ext  = {1'b0, divisor};
        t1       = {rem_reg, div_reg[DIV_W-1]};
        r1       = (t1 >= dvs_ext) ? (t1 - dvs_ext) : t1;
        t2       = {r1[DW-1:0], div_reg[DIV_W-2]};
        r2       = (t2 >= dvs_ext) ? (t2 - dvs_ext) : t2;
        div_next = div_reg;
        rem_next = rem_reg;
        if (ctrl.start)
        begin
            div_next = {{(DIV_W-RAND_W){1'b0}}, word};
            rem_next = '0;
        end
        else if (ctrl.step)
        begin
            div_next = {div_reg[DIV_W-3:0], 2'b00};
            rem_next = r2[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
    end

    assign rem = rem_reg;

endmodule

`default_nettype wire

>>> rtl/rpar_hist.sv
// Recent-id history and the merge stage that picks the first lane result not in it, or lane 0 when retry is off.
// Depends on rpar_pkg for the lane count.
`default_nettype none

module rpar_hist #(
    parameter int DEPTH = 4,
    parameter int ID_W  = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [ID_W-1:0] cand [rpar_pkg::NUM_LANES],
    input  wire logic            retry_en,
    input  wire logic            push,
    output logic      [ID_W-1:0] chosen
);
    import rpar_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [ID_W-1:0]   hist_reg  [DEPTH];
    logic [ID_W-1:0]   hist_next [DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [NUM_LANES-1:0] hit;

    // Each lane result is checked against the valid part of the history in parallel.
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            hit[k] = 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                if ((FILL_W'(i) < fill_reg) && (hist_reg[i] == cand[k]))
                begin
                    hit[k] = 1'b1;
                end
            end
        end
    end

    // The last retry word is taken even when it is a recent id.
    always_comb
    begin
        chosen = cand[NUM_LANES-1];
        for (int k = NUM_LANES - 2; k >= 0; k--)
        begin
            if (!hit[k])
            begin
                chosen = cand[k];
            end
        end
        if (!retry_en)
        begin
            chosen = cand[0];
        end
    end

    always_comb
    begin
        hist_next = hist_reg;
        fill_next = fill_reg;
        if (push)
        begin
            if (fill_reg < FILL_W'(DEPTH))
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (fill_reg == FILL_W'(i))
                    begin
                        hist_next[i] = chosen;
                    end
                end
                fill_next = fill_reg + FILL_W'(1);
            end
            else
            begin
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    hist_next[i] = hist_reg[i + 1];
                end
                hist_next[DEPTH-1] = chosen;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // History entries are only read below the fill count, so they need no reset.
    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

endmodule

`default_nettype wire

>>> rtl/random_pick_avoid_recent_top.sv
// A request that picks a sound loads the lanes on the accepting edge, runs the two-bit remainder
// steps in the division state, then waits in the pick (merge) state until the output register
// is free and registers its result there. No new request is taken until a picking request
// leaves the pick state; requests that give no result retire on their input beat.
// The remainder lanes set the pace: nine of them run side by side, one per random word.
// Reset: rst_n clears the sequencer, output valid, throttle count, history fill and
// both configuration registers; history entries are not cleared.
`default_nettype none

module random_pick_avoid_recent_top #(
    parameter int RECENT_DEPTH = rpar_pkg::RECENT_DEPTH_DEF,
    parameter int MAX_SOUNDS   = rpar_pkg::MAX_SOUNDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire rpar_pkg::in_beat_t            in_data,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rpar_pkg::out_beat_t                out_data,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rpar_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rpar_pkg::PDATA_W-1:0]  pwdata,
    output logic      [rpar_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import rpar_pkg::*;

    // The count register is 9 bits wide, so a clamp above 511 never takes effect.
    localparam int SC_MAX = (MAX_SOUNDS < 511) ? MAX_SOUNDS : 511;
    // Width of the clamped count and of an id below it.
    localparam int DW     = $clog2(SC_MAX + 1);
    localparam int ID_W   = $clog2(SC_MAX);

    rpar_state_t      state_reg;
    rpar_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [SC_W-1:0]  sc_reg;
    logic [NTH_W-1:0] nth_reg;
    logic [NTH_W-1:0] thr_reg;
    logic [NTH_W-1:0] thr_next;
    logic [NTH_W-1:0] thr_inc;
    logic [TYPE_W-1:0] type_reg;
    logic [TYPE_W-1:0] type_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_beat_t        out_reg;
    out_beat_t        out_next;

    logic [DW-1:0]    sc_eff;
    logic             retry_en;
    logic             fire;
    logic             push;
    logic             cfg_wr;
    lane_ctrl_t       ctrl;
    logic [RAND_W-1:0] words [NUM_LANES];
    logic [DW-1:0]    rems   [NUM_LANES];
    logic [ID_W-1:0]  cand   [NUM_LANES];
    logic [ID_W-1:0]  chosen;

    // ------------------------------------------------------------------
    // Configuration port. Writes land in the access phase; reads are
    // served combinationally, so there are never wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg  <= '0;
            nth_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[PADDR_W-1])
                REG_SOUND_COUNT: sc_reg  <= pwdata[SC_W-1:0];
                REG_PLAY_NTH:    nth_reg <= pwdata[NTH_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[PADDR_W-1])
            REG_SOUND_COUNT: prdata = PDATA_W'(sc_reg);
            REG_PLAY_NTH:    prdata = PDATA_W'(nth_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Count clamp and retry decision. The user must change configuration only while the
    // block is idle (the block does not enforce it), so these hold steady for the whole of a pick.
    // ------------------------------------------------------------------
    assign sc_eff   = (sc_reg > SC_W'(SC_MAX)) ? DW'(SC_MAX) : DW'(sc_reg);
    assign retry_en = (32'(sc_eff) > 32'(RECENT_DEPTH));
    assign thr_inc  = thr_reg + NTH_W'(1);

    // ------------------------------------------------------------------
    // Remainder lanes: one per random word, all started on the same beat.
    // ------------------------------------------------------------------
    assign words[0] = in_data.random_0;
    assign words[1] = in_data.random_1;
    assign words[2] = in_data.random_2;
    assign words[3] = in_data.random_3;
    assign words[4] = in_data.random_4;
    assign words[5] = in_data.random_5;
    assign words[6] = in_data.random_6;
    assign words[7] = in_data.random_7;
    assign words[8] = in_data.random_8;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        rpar_mod_lane #(
            .DW (DW)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .word    (words[g]),
            .divisor (sc_eff),
            .rem     (rems[g])
        );

        // A remainder is below the clamped count, so it fits in an id.
        assign cand[g] = ID_W'(rems[g]);
    end

    // ------------------------------------------------------------------
    // Merge stage and recent history.
    // ------------------------------------------------------------------
    rpar_hist #(
        .DEPTH (RECENT_DEPTH),
        .ID_W  (ID_W)
    ) u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .cand     (cand),
        .retry_en (retry_en),
        .push     (push),
        .chosen   (chosen)
    );

    // ------------------------------------------------------------------
    // Sequencer. A request with no sounds configured, or one swallowed by
    // the throttle, retires on its input beat. A picking request runs the
    // lanes, then waits in the merge state until the output register is
    // free; a result left in the output register may still be waiting
    // while the next request is taken.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        thr_next       = thr_reg;
        type_next      = type_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ctrl           = '0;
        push           = 1'b0;
        fire           = 1'b0;
        in_ready       = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (sc_eff != '0))
                begin
                    if (nth_reg > NTH_W'(1))
                    begin
                        fire     = (thr_inc >= nth_reg);
                        thr_next = fire ? '0 : thr_inc;
                    end
                    else
                    begin
                        fire = 1'b1;
                    end
                    if (fire)
                    begin
                        ctrl.start = 1'b1;
                        type_next  = in_data.sound_type_in;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    push                    = 1'b1;
                    out_next.sound_id       = SOUND_ID_W'(chosen);
                    out_next.sound_type_out = type_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
